>>> rtl/core/dms_pkg.sv
// Shared types, codes and constants of the dispenser motor sequencer.
package dms_pkg;

    // Field widths.
    localparam int unsigned KindW   = 2;
    localparam int unsigned CycleW  = 8;
    localparam int unsigned TicksW  = 16;
    localparam int unsigned PulseW  = 16;
    localparam int unsigned NewPulW = 4;
    localparam int unsigned PhaseW  = 3;
    localparam int unsigned DriveW  = 2;
    localparam int unsigned CfgIdxW = 2;

    localparam int unsigned InDataW  = 32;
    localparam int unsigned OutDataW = 24;

    // Input word kinds.
    localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
    localparam logic [KindW-1:0] KIND_START = 2'd1;
    localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;

    // Motor drive codes.
    localparam logic [DriveW-1:0] DRIVE_STOP = 2'd0;
    localparam logic [DriveW-1:0] DRIVE_FWD  = 2'd1;
    localparam logic [DriveW-1:0] DRIVE_REV  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CfgIdxW-1:0] REG_FORWARD_RUN     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_REVERSE_TIMEOUT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PAUSE           = 2'd2;

    localparam logic [TicksW-1:0] FORWARD_RUN_RESET     = 16'd2000;
    localparam logic [TicksW-1:0] REVERSE_TIMEOUT_RESET = 16'd5000;
    localparam logic [TicksW-1:0] PAUSE_RESET           = 16'd200;

    // Result word, packed from the lowest bit up (last member lowest).
    typedef struct packed {
        logic [OutDataW-19:0] pad;
        logic                 timed_out;
        logic                 finished;
        logic                 fault;
        logic                 busy_res;
        logic [CycleW-1:0]    cycles_done;
        logic [DriveW-1:0]    motor_drive;
        logic [PhaseW-1:0]    phase;
        logic                 accepted;
    } result_t;

endpackage

>>> rtl/core/dispenser_motor_sequencer_unit.sv
// Dispenser motor sequencer: input register, one-pass update, result register.
//
//  channel  | direction | ports                            | word
//  ---------+-----------+----------------------------------+------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser| tick, start or clear command
//  m_       | out       | m_tvalid m_tready m_tdata        | status after each command
//  cfg_     | in        | cfg_valid cfg_ready cfg_index    | register write, always ready
//           |           | cfg_data                         |
//
// Each accepted input word waits in the input register, where the update logic
// works on it until the result register can take its result. A new word
// is accepted every cycle while results are taken. A stall on m_ holds the
// result register and then the input register; s_tready falls only when both
// are full. Reset (aresetn low at a clock edge) empties both stages, returns the
// sequencer to idle and loads the register reset values.
module dispenser_motor_sequencer_unit
    import dms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] cycle_target, [23:8] pulse_target, [27:24] new_pulses,
    // [28] food_present, [31:29] zero
    input  logic [InDataW-1:0]   s_tdata,
    // [1:0] kind
    input  logic [KindW-1:0]     s_tuser,
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] accepted, [3:1] phase, [5:4] motor_drive, [13:6] cycles_done,
    // [14] busy_res, [15] fault, [16] finished, [17] timed_out, [23:18] zero
    output logic [OutDataW-1:0]  m_tdata,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [TicksW-1:0]    cfg_data
);

    // Sequencer phases.
    localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
    localparam logic [PhaseW-1:0] PH_FWD       = 3'd1;
    localparam logic [PhaseW-1:0] PH_REV       = 3'd2;
    localparam logic [PhaseW-1:0] PH_ERR       = 3'd3;
    localparam logic [PhaseW-1:0] PH_PAUSE_REV = 3'd4;
    localparam logic [PhaseW-1:0] PH_PAUSE_FWD = 3'd5;

    localparam logic [TicksW-1:0] TICKS_MAX = {TicksW{1'b1}};
    localparam logic [PulseW-1:0] PULSE_MAX = {PulseW{1'b1}};
    localparam logic [CycleW-1:0] CYCLE_MAX = {CycleW{1'b1}};

    // Configuration registers.
    logic [TicksW-1:0] forward_run_reg;
    logic [TicksW-1:0] reverse_timeout_reg;
    logic [TicksW-1:0] pause_reg;

    // Input register.
    logic               in_valid_reg;
    logic [KindW-1:0]   in_kind_reg;
    logic [CycleW-1:0]  in_cycle_target_reg;
    logic [PulseW-1:0]  in_pulse_target_reg;
    logic [NewPulW-1:0] in_new_pulses_reg;
    logic               in_food_reg;

    // Sequencer state.
    logic [PhaseW-1:0] phase_reg,      phase_next;
    logic [TicksW-1:0] elapsed_reg,    elapsed_next;
    logic [PulseW-1:0] pulse_reg,      pulse_next;
    logic [CycleW-1:0] cycle_reg,      cycle_next;
    logic [CycleW-1:0] cycle_goal_reg, cycle_goal_next;
    logic [PulseW-1:0] pulse_goal_reg, pulse_goal_next;

    // Result register.
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic advance;

    // Move a word from the input register to the result register when the
    // result register is empty or being emptied this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_run_reg     <= FORWARD_RUN_RESET;
            reverse_timeout_reg <= REVERSE_TIMEOUT_RESET;
            pause_reg           <= PAUSE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FORWARD_RUN:     forward_run_reg     <= cfg_data;
                REG_REVERSE_TIMEOUT: reverse_timeout_reg <= cfg_data;
                REG_PAUSE:           pause_reg           <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg         <= s_tuser;
            in_cycle_target_reg <= s_tdata[7:0];
            in_pulse_target_reg <= s_tdata[23:8];
            in_new_pulses_reg   <= s_tdata[27:24];
            in_food_reg         <= s_tdata[28];
        end
    end

    // One-pass sequencer update for the word in the input register.
    always_comb begin
        logic [TicksW-1:0] elapsed_inc;
        logic [PulseW:0]   pulse_sum;
        logic [PulseW-1:0] pulse_sat;
        logic [CycleW-1:0] cycle_inc;
        logic              acc;
        logic              done;
        logic              tmo;

        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        pulse_next      = pulse_reg;
        cycle_next      = cycle_reg;
        cycle_goal_next = cycle_goal_reg;
        pulse_goal_next = pulse_goal_reg;
        acc             = 1'b0;
        done            = 1'b0;
        tmo             = 1'b0;

        elapsed_inc = (elapsed_reg == TICKS_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        pulse_sum   = {1'b0, pulse_reg} + {{(PulseW + 1 - NewPulW){1'b0}}, in_new_pulses_reg};
        pulse_sat   = pulse_sum[PulseW] ? PULSE_MAX : pulse_sum[PulseW-1:0];
        cycle_inc   = (cycle_reg == CYCLE_MAX) ? cycle_reg : cycle_reg + 1'b1;

        unique case (in_kind_reg)
            KIND_TICK: begin
                unique case (phase_reg) inside
                    PH_FWD: begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= forward_run_reg) begin
                            phase_next   = (pause_reg == '0) ? PH_REV : PH_PAUSE_REV;
                            elapsed_next = '0;
                            pulse_next   = '0;
                        end
                    end
                    PH_PAUSE_REV, PH_PAUSE_FWD: begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= pause_reg) begin
                            phase_next   = (phase_reg == PH_PAUSE_REV) ? PH_REV : PH_FWD;
                            elapsed_next = '0;
                            pulse_next   = '0;
                        end
                    end
                    PH_REV: begin
                        elapsed_next = elapsed_inc;
                        pulse_next   = pulse_sat;
                        if (pulse_sat >= pulse_goal_reg) begin
                            // Side complete: count it, then finish or turn round.
                            cycle_next   = cycle_inc;
                            elapsed_next = '0;
                            pulse_next   = '0;
                            if (cycle_inc >= cycle_goal_reg) begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end else begin
                                phase_next = (pause_reg == '0) ? PH_FWD : PH_PAUSE_FWD;
                            end
                        end else if (elapsed_inc >= reverse_timeout_reg) begin
                            phase_next = PH_ERR;
                            tmo        = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_START: begin
                // Error clears first; then start only from idle with food.
                if (phase_reg == PH_ERR) begin
                    phase_next = PH_IDLE;
                end
                if ((phase_reg == PH_ERR || phase_reg == PH_IDLE) && in_food_reg) begin
                    cycle_goal_next = in_cycle_target_reg;
                    pulse_goal_next = in_pulse_target_reg;
                    cycle_next      = '0;
                    phase_next      = PH_FWD;
                    elapsed_next    = '0;
                    pulse_next      = '0;
                    acc             = 1'b1;
                end
            end
            KIND_CLEAR: begin
                if (phase_reg == PH_ERR) begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase

        out_next             = '0;
        out_next.accepted    = acc;
        out_next.phase       = phase_next;
        out_next.cycles_done = cycle_next;
        out_next.finished    = done;
        out_next.timed_out   = tmo;
        out_next.fault       = (phase_next == PH_ERR);
        out_next.busy_res    = (phase_next == PH_FWD) || (phase_next == PH_REV) ||
                               (phase_next == PH_PAUSE_REV) || (phase_next == PH_PAUSE_FWD);
        if (phase_next == PH_FWD) begin
            out_next.motor_drive = DRIVE_FWD;
        end else if (phase_next == PH_REV) begin
            out_next.motor_drive = DRIVE_REV;
        end else begin
            out_next.motor_drive = DRIVE_STOP;
        end
    end

    // Sequencer state advances once per word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            pulse_reg      <= '0;
            cycle_reg      <= '0;
            cycle_goal_reg <= '0;
            pulse_goal_reg <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            pulse_reg      <= pulse_next;
            cycle_reg      <= cycle_next;
            cycle_goal_reg <= cycle_goal_next;
            pulse_goal_reg <= pulse_goal_next;
        end
    end

    // Result register: hold while stalled, load on advance, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Phase never leaves the six defined codes.
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_PAUSE_FWD)
        else $error("sequencer phase outside defined codes");

    // A timeout always lands the sequencer in error.
    a_timeout_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_next.timed_out |=> phase_reg == PH_ERR && out_reg.fault)
        else $error("timeout without error phase");

    // A completed dispense leaves the motor stopped and idle.
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_next.finished |=> phase_reg == PH_IDLE &&
        out_reg.motor_drive == DRIVE_STOP && !out_reg.busy_res)
        else $error("finished dispense not idle");

    // An accepted start always begins with a forward run from a fresh count.
    a_start_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_next.accepted |=> phase_reg == PH_FWD && cycle_reg == '0 &&
        elapsed_reg == '0)
        else $error("accepted start did not enter forward run");

endmodule
